/* src/tild_pkg.sv */
// Package with shared types and constants of the terminal input line discipline.
package tild_pkg;

    typedef enum logic [3:0] {
        EV_STORED       = 4'd0,
        EV_FULL_DROP    = 4'd1,
        EV_CR_IGNORED   = 4'd2,
        EV_INTERRUPT    = 4'd3,
        EV_SUSPEND      = 4'd4,
        EV_EOF_MARKED   = 4'd5,
        EV_EDITED       = 4'd6,
        EV_TAKEN        = 4'd7,
        EV_EMPTY        = 4'd8,
        EV_EOF_CONSUMED = 4'd9,
        EV_FLUSHED      = 4'd10
    } t_event;

    typedef enum logic [1:0] {
        CMD_RECEIVE = 2'd0,
        CMD_TAKE    = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_FLUSH_ALT = 2'd3
    } t_command;

    typedef enum logic [3:0] {
        ACT_FLUSH,
        ACT_TAKE,
        ACT_IGNORE,
        ACT_INTERRUPT,
        ACT_SUSPEND,
        ACT_EOF_MARK,
        ACT_ERASE,
        ACT_KILL,
        ACT_WORD_ERASE,
        ACT_STORE
    } t_action;

    typedef enum logic [1:0] {
        WALK_ANY,
        WALK_SPACES,
        WALK_WORD
    } t_walk;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TAKE_WAIT,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic take_rd;
        logic take_fin;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic walk_phase;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        t_action action;
        logic    empty;
        logic    walk_more;
        logic    walk_ok;
        logic    walk_spaces;
        logic    out_free;
    } t_dp_status;

    localparam logic [2:0] CFG_INPUT_FLAGS = 3'd0;
    localparam logic [2:0] CFG_LOCAL_FLAGS = 3'd1;
    localparam logic [2:0] CFG_INTR_CHAR   = 3'd2;
    localparam logic [2:0] CFG_SUSP_CHAR   = 3'd3;
    localparam logic [2:0] CFG_EOF_CHAR    = 3'd4;
    localparam logic [2:0] CFG_ERASE_CHAR  = 3'd5;
    localparam logic [2:0] CFG_KILL_CHAR   = 3'd6;
    localparam logic [2:0] CFG_WERASE_CHAR = 3'd7;

    localparam logic [2:0] RST_INPUT_FLAGS = 3'd2;
    localparam logic [2:0] RST_LOCAL_FLAGS = 3'd3;
    localparam logic [7:0] RST_INTR_CHAR   = 8'h03;
    localparam logic [7:0] RST_SUSP_CHAR   = 8'h1A;
    localparam logic [7:0] RST_EOF_CHAR    = 8'h04;
    localparam logic [7:0] RST_ERASE_CHAR  = 8'h7F;
    localparam logic [7:0] RST_KILL_CHAR   = 8'h15;
    localparam logic [7:0] RST_WERASE_CHAR = 8'h17;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;

    function automatic logic is_line_end(input logic [7:0] b);
        return (b == CH_NL) || (b == CH_CR);
    endfunction

endpackage

/* src/tild_ifs.sv */
// Handshake channel interfaces for input items, result items and configuration writes.
interface tild_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface tild_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] data_byte;
    logic       echo_valid;
    logic [5:0] erase_count;
    logic       wake_reader;
    logic [5:0] fill_level;
    logic       eof_flag;

    modport source (output valid, output event_res, output data_byte, output echo_valid,
                    output erase_count, output wake_reader, output fill_level,
                    output eof_flag, input ready);
    modport sink (input valid, input event_res, input data_byte, input echo_valid,
                  input erase_count, input wake_reader, input fill_level,
                  input eof_flag, output ready);
endinterface

interface tild_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] reg_index;
    logic [7:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

/* src/tild_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module tild_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tild_ctrl.sv */
// Controller state machine that sequences each item through the datapath.
module tild_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tild_pkg::t_dp_status i_status,
    output tild_pkg::t_ctl_cmd   o_cmd
);

    tild_pkg::t_state r_state;
    tild_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tild_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tild_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tild_pkg::ST_EXEC;
                end
            end
            tild_pkg::ST_EXEC: begin
                unique case (i_status.action)
                    tild_pkg::ACT_TAKE: begin
                        n_state = i_status.empty ? tild_pkg::ST_FINISH
                                                 : tild_pkg::ST_TAKE_WAIT;
                    end
                    tild_pkg::ACT_ERASE, tild_pkg::ACT_KILL, tild_pkg::ACT_WORD_ERASE: begin
                        n_state = tild_pkg::ST_WALK_RD;
                    end
                    default: begin
                        n_state = tild_pkg::ST_FINISH;
                    end
                endcase
            end
            tild_pkg::ST_TAKE_WAIT: begin
                n_state = tild_pkg::ST_FINISH;
            end
            tild_pkg::ST_WALK_RD: begin
                n_state = i_status.walk_more ? tild_pkg::ST_WALK_CHK : tild_pkg::ST_FINISH;
            end
            tild_pkg::ST_WALK_CHK: begin
                if (i_status.walk_ok || i_status.walk_spaces) begin
                    n_state = tild_pkg::ST_WALK_RD;
                end else begin
                    n_state = tild_pkg::ST_FINISH;
                end
            end
            tild_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = tild_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tild_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tild_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            tild_pkg::ST_EXEC: begin
                unique case (i_status.action)
                    tild_pkg::ACT_TAKE: begin
                        o_cmd.exec    = i_status.empty;
                        o_cmd.take_rd = !i_status.empty;
                    end
                    tild_pkg::ACT_ERASE, tild_pkg::ACT_KILL, tild_pkg::ACT_WORD_ERASE: begin
                        o_cmd.walk_init = 1'b1;
                    end
                    default: begin
                        o_cmd.exec = 1'b1;
                    end
                endcase
            end
            tild_pkg::ST_TAKE_WAIT: begin
                o_cmd.take_fin = 1'b1;
            end
            tild_pkg::ST_WALK_RD: begin
                o_cmd.walk_rd = i_status.walk_more;
            end
            tild_pkg::ST_WALK_CHK: begin
                o_cmd.walk_step  = i_status.walk_ok;
                o_cmd.walk_phase = !i_status.walk_ok && i_status.walk_spaces;
            end
            tild_pkg::ST_FINISH: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/tild_dp.sv */
// Datapath with the byte ring, indices, configuration registers and result register.
module tild_dp #(
    parameter int RING_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tild_pkg::t_ctl_cmd   i_cmd,
    output tild_pkg::t_dp_status o_status,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [3:0]           o_event_res,
    output logic [7:0]           o_data_byte,
    output logic                 o_echo_valid,
    output logic [5:0]           o_erase_count,
    output logic                 o_wake_reader,
    output logic [5:0]           o_fill_level,
    output logic                 o_eof_flag
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(RING_DEPTH);

    logic [AW-1:0] r_wr_idx;
    logic [AW-1:0] r_rd_idx;
    logic          r_eof;
    logic [2:0]    r_iflags;
    logic [2:0]    r_lflags;
    logic [7:0]    r_intr_ch;
    logic [7:0]    r_susp_ch;
    logic [7:0]    r_eof_ch;
    logic [7:0]    r_erase_ch;
    logic [7:0]    r_kill_ch;
    logic [7:0]    r_werase_ch;
    logic          r_out_valid;

    logic [1:0]       r_cmd;
    logic [7:0]       r_byte;
    logic             r_ign;
    tild_pkg::t_event r_ev;
    logic [7:0]       r_data;
    logic             r_echo;
    logic             r_wake;
    logic [AW-1:0]    r_cnt;
    logic             r_one;
    tild_pkg::t_walk  r_mode;

    tild_pkg::t_event r_out_ev;
    logic [7:0]       r_out_data;
    logic             r_out_echo;
    logic [5:0]       r_out_cnt;
    logic             r_out_wake;
    logic [5:0]       r_out_fill;
    logic             r_out_eof;

    logic [7:0]       n_byte;
    logic             n_ign;
    tild_pkg::t_action w_action;
    logic             w_canon_echo;
    logic [AW-1:0]    w_prev_wr;
    logic [AW-1:0]    w_next_wr;
    logic [AW-1:0]    w_next_rd;
    logic             w_empty;
    logic             w_full;
    logic [7:0]       w_rdata;
    logic             w_ram_we;
    logic             w_ram_re;
    logic [AW-1:0]    w_raddr;
    logic             w_walk_ok;
    logic [AW:0]      w_diff;
    logic [AW:0]      w_fill;
    logic [AW+5:0]    w_fill_ext;
    logic [AW+5:0]    w_cnt_ext;

    assign w_canon_echo = r_lflags[1] && r_lflags[2];
    assign w_prev_wr    = (r_wr_idx == '0) ? LAST_IDX : r_wr_idx - AW'(1);
    assign w_next_wr    = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
    assign w_next_rd    = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);
    assign w_empty      = (r_wr_idx == r_rd_idx);
    assign w_full       = (w_next_wr == r_rd_idx);

    always_comb begin
        n_byte = i_rx_byte;
        n_ign  = 1'b0;
        if (i_rx_byte == tild_pkg::CH_CR) begin
            if (r_iflags[0]) begin
                n_ign = 1'b1;
            end else if (r_iflags[1]) begin
                n_byte = tild_pkg::CH_NL;
            end
        end else if (i_rx_byte == tild_pkg::CH_NL && r_iflags[2]) begin
            n_byte = tild_pkg::CH_CR;
        end
    end

    always_comb begin
        if (r_cmd[1]) begin
            w_action = tild_pkg::ACT_FLUSH;
        end else if (r_cmd == tild_pkg::CMD_TAKE) begin
            w_action = tild_pkg::ACT_TAKE;
        end else if (r_ign) begin
            w_action = tild_pkg::ACT_IGNORE;
        end else if (r_lflags[0] && r_byte == r_intr_ch) begin
            w_action = tild_pkg::ACT_INTERRUPT;
        end else if (r_lflags[0] && r_byte == r_susp_ch) begin
            w_action = tild_pkg::ACT_SUSPEND;
        end else if (w_canon_echo && r_byte == r_eof_ch) begin
            w_action = tild_pkg::ACT_EOF_MARK;
        end else if (w_canon_echo && (r_byte == tild_pkg::CH_BS || r_byte == r_erase_ch)) begin
            w_action = tild_pkg::ACT_ERASE;
        end else if (w_canon_echo && r_byte == r_kill_ch) begin
            w_action = tild_pkg::ACT_KILL;
        end else if (w_canon_echo && r_byte == r_werase_ch) begin
            w_action = tild_pkg::ACT_WORD_ERASE;
        end else begin
            w_action = tild_pkg::ACT_STORE;
        end
    end

    always_comb begin
        w_walk_ok = !tild_pkg::is_line_end(w_rdata);
        case (r_mode)
            tild_pkg::WALK_SPACES: w_walk_ok = w_walk_ok && (w_rdata == tild_pkg::CH_SP);
            tild_pkg::WALK_WORD:   w_walk_ok = w_walk_ok && (w_rdata != tild_pkg::CH_SP);
            default:               w_walk_ok = w_walk_ok;
        endcase
    end

    assign w_ram_we = i_cmd.exec && (w_action == tild_pkg::ACT_STORE) && !w_full;
    assign w_ram_re = i_cmd.take_rd || i_cmd.walk_rd;
    assign w_raddr  = i_cmd.take_rd ? r_rd_idx : w_prev_wr;

    tild_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (r_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_status.action      = w_action;
    assign o_status.empty       = w_empty;
    assign o_status.walk_more   = !w_empty && !(r_one && r_cnt != '0);
    assign o_status.walk_ok     = w_walk_ok;
    assign o_status.walk_spaces = (r_mode == tild_pkg::WALK_SPACES);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign w_diff     = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
    assign w_fill     = w_diff[AW] ? w_diff + DEPTH_EXT : w_diff;
    assign w_fill_ext = {5'd0, w_fill};
    assign w_cnt_ext  = {6'd0, r_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_eof       <= 1'b0;
            r_iflags    <= tild_pkg::RST_INPUT_FLAGS;
            r_lflags    <= tild_pkg::RST_LOCAL_FLAGS;
            r_intr_ch   <= tild_pkg::RST_INTR_CHAR;
            r_susp_ch   <= tild_pkg::RST_SUSP_CHAR;
            r_eof_ch    <= tild_pkg::RST_EOF_CHAR;
            r_erase_ch  <= tild_pkg::RST_ERASE_CHAR;
            r_kill_ch   <= tild_pkg::RST_KILL_CHAR;
            r_werase_ch <= tild_pkg::RST_WERASE_CHAR;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tild_pkg::CFG_INPUT_FLAGS: r_iflags    <= i_cfg_data[2:0];
                    tild_pkg::CFG_LOCAL_FLAGS: r_lflags    <= i_cfg_data[2:0];
                    tild_pkg::CFG_INTR_CHAR:   r_intr_ch   <= i_cfg_data;
                    tild_pkg::CFG_SUSP_CHAR:   r_susp_ch   <= i_cfg_data;
                    tild_pkg::CFG_EOF_CHAR:    r_eof_ch    <= i_cfg_data;
                    tild_pkg::CFG_ERASE_CHAR:  r_erase_ch  <= i_cfg_data;
                    tild_pkg::CFG_KILL_CHAR:   r_kill_ch   <= i_cfg_data;
                    tild_pkg::CFG_WERASE_CHAR: r_werase_ch <= i_cfg_data;
                    default:                   r_werase_ch <= r_werase_ch;
                endcase
            end
            if (i_cmd.exec) begin
                case (w_action)
                    tild_pkg::ACT_FLUSH: begin
                        r_wr_idx <= '0;
                        r_rd_idx <= '0;
                        r_eof    <= 1'b0;
                    end
                    tild_pkg::ACT_TAKE: begin
                        r_eof <= 1'b0;
                    end
                    tild_pkg::ACT_EOF_MARK: begin
                        r_eof <= 1'b1;
                    end
                    tild_pkg::ACT_STORE: begin
                        if (!w_full) begin
                            r_wr_idx <= w_next_wr;
                        end
                    end
                    default: begin
                        r_eof <= r_eof;
                    end
                endcase
            end
            if (i_cmd.take_fin) begin
                r_rd_idx <= w_next_rd;
            end
            if (i_cmd.walk_step) begin
                r_wr_idx <= w_prev_wr;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_command;
            r_byte <= n_byte;
            r_ign  <= n_ign;
        end
        if (i_cmd.exec) begin
            r_data <= (w_action == tild_pkg::ACT_FLUSH || w_action == tild_pkg::ACT_TAKE)
                      ? '0 : r_byte;
            r_echo <= (w_action == tild_pkg::ACT_STORE) && r_lflags[2];
            r_cnt  <= '0;
            case (w_action)
                tild_pkg::ACT_FLUSH: begin
                    r_ev   <= tild_pkg::EV_FLUSHED;
                    r_wake <= 1'b0;
                end
                tild_pkg::ACT_TAKE: begin
                    r_ev   <= r_eof ? tild_pkg::EV_EOF_CONSUMED : tild_pkg::EV_EMPTY;
                    r_wake <= 1'b0;
                end
                tild_pkg::ACT_IGNORE: begin
                    r_ev   <= tild_pkg::EV_CR_IGNORED;
                    r_wake <= 1'b0;
                end
                tild_pkg::ACT_INTERRUPT: begin
                    r_ev   <= tild_pkg::EV_INTERRUPT;
                    r_wake <= 1'b0;
                end
                tild_pkg::ACT_SUSPEND: begin
                    r_ev   <= tild_pkg::EV_SUSPEND;
                    r_wake <= 1'b0;
                end
                tild_pkg::ACT_EOF_MARK: begin
                    r_ev   <= tild_pkg::EV_EOF_MARKED;
                    r_wake <= 1'b1;
                end
                default: begin
                    if (w_full) begin
                        r_ev   <= tild_pkg::EV_FULL_DROP;
                        r_wake <= 1'b0;
                    end else begin
                        r_ev   <= tild_pkg::EV_STORED;
                        r_wake <= w_canon_echo ? tild_pkg::is_line_end(r_byte) : 1'b1;
                    end
                end
            endcase
        end
        if (i_cmd.take_fin) begin
            r_ev   <= tild_pkg::EV_TAKEN;
            r_data <= w_rdata;
            r_echo <= 1'b0;
            r_wake <= 1'b0;
            r_cnt  <= '0;
        end
        if (i_cmd.walk_init) begin
            r_ev   <= tild_pkg::EV_EDITED;
            r_data <= r_byte;
            r_echo <= 1'b0;
            r_wake <= 1'b0;
            r_cnt  <= '0;
            r_one  <= (w_action == tild_pkg::ACT_ERASE);
            case (w_action)
                tild_pkg::ACT_WORD_ERASE: r_mode <= tild_pkg::WALK_SPACES;
                default:                  r_mode <= tild_pkg::WALK_ANY;
            endcase
        end
        if (i_cmd.walk_step) begin
            r_cnt <= r_cnt + AW'(1);
        end
        if (i_cmd.walk_phase) begin
            r_mode <= tild_pkg::WALK_WORD;
        end
        if (i_cmd.load_out) begin
            r_out_ev   <= r_ev;
            r_out_data <= r_data;
            r_out_echo <= r_echo;
            r_out_cnt  <= w_cnt_ext[5:0];
            r_out_wake <= r_wake;
            r_out_fill <= w_fill_ext[5:0];
            r_out_eof  <= r_eof;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_res   = r_out_ev;
    assign o_data_byte   = r_out_data;
    assign o_echo_valid  = r_out_echo;
    assign o_erase_count = r_out_cnt;
    assign o_wake_reader = r_out_wake;
    assign o_fill_level  = r_out_fill;
    assign o_eof_flag    = r_out_eof;

endmodule

/* src/tty_input_line_discipline.sv */
// Top level of the terminal input line discipline: controller, datapath and channel wiring.
// Each item passes the execute and finish states, the latter loading the result; a take
// of a stored byte also passes the take-wait state, and an edit loops over the walk read and
// check states while it removes bytes; a stalled result holds the controller until taken.
// Throughput: one item at a time, the next accepted the cycle after the result is loaded.
// Reset clears the indices, the end-of-file mark, the result valid and sets the registers
// to their defaults; ring contents are left as they are and need no clearing pass.
module tty_input_line_discipline #(
    parameter int RING_DEPTH = 64
) (
    input logic              i_clk,
    input logic              i_rst_n,
    tild_in_if.sink          i_in,
    tild_out_if.source       o_out,
    tild_cfg_if.sink         i_cfg
);

    tild_pkg::t_ctl_cmd   w_cmd;
    tild_pkg::t_dp_status w_status;
    logic                 w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    tild_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tild_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_command     (i_in.command),
        .i_rx_byte     (i_in.rx_byte),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.reg_index),
        .i_cfg_data    (i_cfg.wr_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_event_res   (o_out.event_res),
        .o_data_byte   (o_out.data_byte),
        .o_echo_valid  (o_out.echo_valid),
        .o_erase_count (o_out.erase_count),
        .o_wake_reader (o_out.wake_reader),
        .o_fill_level  (o_out.fill_level),
        .o_eof_flag    (o_out.eof_flag)
    );

endmodule

/* src/tild_checker.sv */
// Port-level checker for the line discipline and its bind to the top level.
module tild_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_event_res,
    input logic       i_echo_valid,
    input logic [5:0] i_erase_count,
    input logic       i_wake_reader,
    input logic [5:0] i_fill_level,
    input logic       i_eof_flag
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_res))
        else $error("result item changed while stalled");

    a_erase_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_erase_count != 6'd0 |-> i_event_res == tild_pkg::EV_EDITED)
        else $error("erase count on a non-edit item");

    a_echo_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_echo_valid |->
            i_event_res == tild_pkg::EV_STORED || i_event_res == tild_pkg::EV_FULL_DROP)
        else $error("echo on an item that did not reach the store stage");

    a_wake_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_wake_reader |->
            i_event_res == tild_pkg::EV_STORED || i_event_res == tild_pkg::EV_EOF_MARKED)
        else $error("reader woken by an item that stored nothing");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == tild_pkg::EV_FLUSHED |->
            i_fill_level == 6'd0 && !i_eof_flag)
        else $error("flush left bytes or an end-of-file mark");

endmodule

bind tty_input_line_discipline tild_checker u_tild_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_res   (o_out.event_res),
    .i_echo_valid  (o_out.echo_valid),
    .i_erase_count (o_out.erase_count),
    .i_wake_reader (o_out.wake_reader),
    .i_fill_level  (o_out.fill_level),
    .i_eof_flag    (o_out.eof_flag)
);

/* tb/tb_tty_input_line_discipline.sv */
// Self-checking testbench of the terminal input line discipline with its own line predictor.
module tb_tty_input_line_discipline;
    import tild_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int ITEM_TARGET = 1100;

    typedef struct packed {
        t_command   cmd;
        logic [7:0] rx;
    } t_tty_request;

    typedef struct packed {
        t_event     ev;
        logic [7:0] data;
        logic       echo;
        logic [5:0] erased;
        logic       wake;
        logic [5:0] fill;
        logic       eof;
    } t_line_result;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_THIRDS,
        PACE_COIN,
        PACE_HOLDS
    } t_pace;

    logic i_clk;
    logic i_rst_n;

    tild_in_if  in_ch ();
    tild_out_if out_ch ();
    tild_cfg_if cfg_ch ();

    tty_input_line_discipline #(
        .RING_DEPTH(64)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor copy of the line ring and the registers.
    logic [7:0] ring_mem [64];
    logic [5:0] wr_ptr;
    logic [5:0] rd_ptr;
    logic       eof_mark;
    logic [2:0] iflags;
    logic [2:0] lflags;
    logic [7:0] intr_ch;
    logic [7:0] susp_ch;
    logic [7:0] eof_ch;
    logic [7:0] erase_ch;
    logic [7:0] kill_ch;
    logic [7:0] werase_ch;

    t_tty_request tty_requests [$];
    t_line_result due_line_results [$];

    int items_issued = 0;
    int results_seen = 0;
    int error_cnt = 0;
    int quiet_cycles = 0;

    t_tty_request cur_req;
    int burst_left = 0;
    int gap_left = 0;

    t_pace pace_mode = PACE_FREE;
    int pace_left = 0;
    int hold_left = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Removes newest bytes back toward the line start and returns how many went.
    function automatic logic [5:0] rub_out(input t_walk mode, input int limit);
        logic [5:0] n;
        logic [7:0] b;
        logic       stop;
        n = '0;
        stop = 1'b0;
        while (!stop && wr_ptr != rd_ptr && n < limit) begin
            b = ring_mem[wr_ptr - 6'd1];
            if (b == CH_NL || b == CH_CR || (mode == WALK_SPACES && b != CH_SP)
                    || (mode == WALK_WORD && b == CH_SP)) begin
                stop = 1'b1;
            end else begin
                wr_ptr = wr_ptr - 6'd1;
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

    function automatic t_line_result predict_line_step(input t_tty_request req);
        t_line_result r;
        logic [7:0]   c;
        logic         canon_echo;
        logic         cr_drop;
        logic [5:0]   nxt;
        r = '{ev: EV_STORED, data: 8'h00, echo: 1'b0, erased: 6'd0, wake: 1'b0,
              fill: 6'd0, eof: 1'b0};
        canon_echo = lflags[1] & lflags[2];
        c = req.rx;
        if (req.cmd[1]) begin
            wr_ptr = '0;
            rd_ptr = '0;
            eof_mark = 1'b0;
            r.ev = EV_FLUSHED;
        end else if (req.cmd == CMD_TAKE) begin
            if (wr_ptr == rd_ptr) begin
                r.ev = eof_mark ? EV_EOF_CONSUMED : EV_EMPTY;
                eof_mark = 1'b0;
            end else begin
                r.data = ring_mem[rd_ptr];
                rd_ptr = rd_ptr + 6'd1;
                r.ev = EV_TAKEN;
            end
        end else begin
            cr_drop = (c == CH_CR) && iflags[0];
            if (c == CH_CR && !iflags[0] && iflags[1]) begin
                c = CH_NL;
            end else if (c == CH_NL && iflags[2]) begin
                c = CH_CR;
            end
            r.data = c;
            if (cr_drop) begin
                r.ev = EV_CR_IGNORED;
            end else if (lflags[0] && c == intr_ch) begin
                r.ev = EV_INTERRUPT;
            end else if (lflags[0] && c == susp_ch) begin
                r.ev = EV_SUSPEND;
            end else if (canon_echo && c == eof_ch) begin
                eof_mark = 1'b1;
                r.ev = EV_EOF_MARKED;
                r.wake = 1'b1;
            end else if (canon_echo && (c == CH_BS || c == erase_ch)) begin
                r.erased = rub_out(WALK_ANY, 1);
                r.ev = EV_EDITED;
            end else if (canon_echo && c == kill_ch) begin
                r.erased = rub_out(WALK_ANY, 64);
                r.ev = EV_EDITED;
            end else if (canon_echo && c == werase_ch) begin
                r.erased = rub_out(WALK_SPACES, 64);
                r.erased = r.erased + rub_out(WALK_WORD, 64);
                r.ev = EV_EDITED;
            end else begin
                nxt = wr_ptr + 6'd1;
                r.echo = lflags[2];
                if (nxt == rd_ptr) begin
                    r.ev = EV_FULL_DROP;
                end else begin
                    ring_mem[wr_ptr] = c;
                    wr_ptr = nxt;
                    r.ev = EV_STORED;
                    r.wake = canon_echo ? (c == CH_NL || c == CH_CR) : 1'b1;
                end
            end
        end
        r.fill = wr_ptr - rd_ptr;
        r.eof = eof_mark;
        return r;
    endfunction

    function automatic string show(input t_line_result r);
        return $sformatf("ev=%0d data=%02h echo=%0b erased=%0d wake=%0b fill=%0d eof=%0b",
                         r.ev, r.data, r.echo, r.erased, r.wake, r.fill, r.eof);
    endfunction

    function automatic void push_item(input t_command cmd, input logic [7:0] b);
        tty_requests.push_back('{cmd: cmd, rx: b});
        items_issued++;
    endfunction

    // Mostly typing: letters, spaces, line ends and the keys the registers make special.
    function automatic logic [7:0] typed_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 8'h61 + 8'($urandom_range(0, 25));
        if (roll < 60) return CH_SP;
        if (roll < 74) begin
            case ($urandom_range(0, 6))
                0: return erase_ch;
                1: return kill_ch;
                2: return werase_ch;
                3: return eof_ch;
                4: return intr_ch;
                5: return susp_ch;
                default: return CH_BS;
            endcase
        end
        if (roll < 84) return $urandom_range(0, 1) ? CH_NL : CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_reg_value(input logic [2:0] idx, input int phase_no);
        logic [7:0] char_picks [10];
        char_picks = '{8'h00, 8'hFF, CH_BS, CH_NL, CH_CR, CH_SP, RST_INTR_CHAR, RST_SUSP_CHAR,
                       RST_ERASE_CHAR, RST_KILL_CHAR};
        if (idx == CFG_LOCAL_FLAGS && phase_no == 0) return 8'h00;
        if (idx == CFG_INPUT_FLAGS || idx == CFG_LOCAL_FLAGS) begin
            case ($urandom_range(0, 3))
                0: return $urandom_range(0, 1) ? 8'h07 : 8'h00;
                1: return 8'h06 | 8'($urandom_range(0, 1));
                default: return 8'($urandom_range(0, 255));
            endcase
        end
        if ($urandom_range(0, 1)) return char_picks[$urandom_range(0, 9)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a rising edge; leaves valid high so back-to-back writes need no gap.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_INPUT_FLAGS: iflags = val[2:0];
            CFG_LOCAL_FLAGS: lflags = val[2:0];
            CFG_INTR_CHAR:   intr_ch = val;
            CFG_SUSP_CHAR:   susp_ch = val;
            CFG_EOF_CHAR:    eof_ch = val;
            CFG_ERASE_CHAR:  erase_ch = val;
            CFG_KILL_CHAR:   kill_ch = val;
            default:         werase_ch = val;
        endcase
    endtask

    task automatic wait_settled();
        do @(posedge i_clk); while (results_seen != items_issued);
    endtask

    task automatic random_phase(input int phase_no);
        int n;
        int take_pct;
        int flush_pct;
        int roll;
        for (int k = CFG_INPUT_FLAGS; k <= CFG_WERASE_CHAR; k++) begin
            if (k == CFG_LOCAL_FLAGS || $urandom_range(0, 1))
                write_reg(3'(k), pick_reg_value(3'(k), phase_no));
        end
        cfg_ch.valid <= 1'b0;
        n = $urandom_range(40, 120);
        case ($urandom_range(0, 3))
            0: take_pct = 0;
            1: take_pct = 10;
            2: take_pct = 30;
            default: take_pct = 45;
        endcase
        flush_pct = (phase_no == 0) ? 0 : $urandom_range(0, 5);
        if (phase_no == 0) take_pct = 0;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < flush_pct)
                push_item($urandom_range(0, 1) ? CMD_FLUSH : CMD_FLUSH_ALT,
                          8'($urandom_range(0, 255)));
            else if (roll < flush_pct + take_pct)
                push_item(CMD_TAKE, 8'($urandom_range(0, 255)));
            else
                push_item(CMD_RECEIVE, typed_byte());
        end
        wait_settled();
    endtask

    // Input driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        t_line_result due;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                due = predict_line_step(cur_req);
                due_line_results.push_back(due);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0 || tty_requests.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    in_ch.valid <= 1'b0;
                end else begin
                    cur_req = tty_requests.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.command <= cur_req.cmd;
                    in_ch.rx_byte <= cur_req.rx;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Result side back-pressure, changing its pattern every so often.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (pace_left == 0) begin
                pace_mode = t_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(16, 160);
            end else begin
                pace_left--;
            end
            case (pace_mode)
                PACE_FREE:   out_ch.ready <= 1'b1;
                PACE_THIRDS: out_ch.ready <= (pace_left % 3) != 0;
                PACE_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_line_result got;
        t_line_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{ev: t_event'(out_ch.event_res), data: out_ch.data_byte,
                    echo: out_ch.echo_valid, erased: out_ch.erase_count,
                    wake: out_ch.wake_reader, fill: out_ch.fill_level, eof: out_ch.eof_flag};
            if (due_line_results.size() == 0) begin
                if (error_cnt < 10) $display("unexpected result: %s", show(got));
                error_cnt++;
            end else begin
                want = due_line_results.pop_front();
                results_seen++;
                if (got !== want) begin
                    if (error_cnt < 10)
                        $display("mismatch on result %0d: expected %s, got %s",
                                 results_seen, show(want), show(got));
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int phase_no;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_RECEIVE;
        in_ch.rx_byte = 8'h00;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = CFG_INPUT_FLAGS;
        cfg_ch.wr_data = 8'h00;
        wr_ptr = '0;
        rd_ptr = '0;
        eof_mark = 1'b0;
        iflags = RST_INPUT_FLAGS;
        lflags = RST_LOCAL_FLAGS;
        intr_ch = RST_INTR_CHAR;
        susp_ch = RST_SUSP_CHAR;
        eof_ch = RST_EOF_CHAR;
        erase_ch = RST_ERASE_CHAR;
        kill_ch = RST_KILL_CHAR;
        werase_ch = RST_WERASE_CHAR;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: CR maps to NL, signals on, canonical without echo.
        push_item(CMD_RECEIVE, 8'h61);
        push_item(CMD_RECEIVE, CH_CR);
        push_item(CMD_RECEIVE, RST_INTR_CHAR);
        push_item(CMD_RECEIVE, RST_SUSP_CHAR);
        push_item(CMD_TAKE, 8'h00);
        push_item(CMD_TAKE, 8'hFF);
        push_item(CMD_TAKE, 8'h00);
        wait_settled();

        // Canonical echo with NL mapped to CR; interrupt and suspend share one key.
        write_reg(CFG_INPUT_FLAGS, 8'h04);
        write_reg(CFG_LOCAL_FLAGS, 8'h07);
        write_reg(CFG_INTR_CHAR, 8'h03);
        write_reg(CFG_SUSP_CHAR, 8'h03);
        write_reg(CFG_EOF_CHAR, 8'h04);
        write_reg(CFG_ERASE_CHAR, 8'h7F);
        write_reg(CFG_KILL_CHAR, 8'h15);
        write_reg(CFG_WERASE_CHAR, 8'h17);
        cfg_ch.valid <= 1'b0;
        push_item(CMD_RECEIVE, 8'h03);
        push_item(CMD_RECEIVE, 8'h04);
        push_item(CMD_TAKE, 8'h00);
        push_item(CMD_RECEIVE, 8'h78);
        push_item(CMD_RECEIVE, CH_SP);
        push_item(CMD_RECEIVE, 8'h79);
        push_item(CMD_RECEIVE, CH_SP);
        push_item(CMD_RECEIVE, 8'h17);
        push_item(CMD_RECEIVE, CH_BS);
        push_item(CMD_RECEIVE, 8'h7F);
        push_item(CMD_RECEIVE, CH_NL);
        push_item(CMD_RECEIVE, 8'hFF);
        push_item(CMD_RECEIVE, 8'h15);
        push_item(CMD_RECEIVE, 8'h7F);
        push_item(CMD_FLUSH_ALT, 8'hFF);
        push_item(CMD_RECEIVE, 8'h00);
        push_item(CMD_FLUSH, 8'h00);
        wait_settled();

        phase_no = 0;
        while (items_issued < ITEM_TARGET) begin
            random_phase(phase_no);
            phase_no++;
        end

        repeat (16) @(posedge i_clk);
        if (error_cnt == 0 && due_line_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
